/* hw/rtl/sliding_window_median_macros.svh */
// Assertion macros shared by the sliding window median checker
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Checked at every edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

// Checked only out of reset
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/swm_pkg.sv */
// Shared types and constants of the sliding window median filter
package swm_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SUM_BITS        = 48;
    localparam int CFG_BITS        = 7;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(3);

    // What a cell hands to its right neighbor
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic                   gt;
    } t_link;

    // Request waiting for the output stage
    typedef struct packed {
        logic prod;
        logic last;
    } t_req;

endpackage

/* hw/rtl/swm_cell.sv */
// One slot of the sorted window: value, age and local shift logic
module swm_cell #(
    parameter int AGE_W = 6
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic                            i_rle,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_nxt_val,
    input  logic [AGE_W-1:0]                i_nxt_age,
    input  logic                            i_valid_n,
    input  logic                            i_live,
    input  logic [AGE_W-1:0]                i_oldest,
    input  swm_pkg::t_link                  i_left,
    input  logic [AGE_W-1:0]                i_left_age,
    output swm_pkg::t_link                  o_link,
    output logic [AGE_W-1:0]                o_s_age,
    output logic [swm_pkg::SAMPLE_BITS-1:0] o_val,
    output logic [AGE_W-1:0]                o_age,
    output logic                            o_hit
);
    import swm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_val, n_val, w_s_val;
    logic [AGE_W-1:0]       r_age, n_age, w_s_age;
    logic                   w_gt;

    // close the gap left by the removed sample
    assign w_s_val = i_rle ? i_nxt_val : r_val;
    assign w_s_age = i_rle ? i_nxt_age : r_age;
    assign w_gt    = i_valid_n && (w_s_val > i_x);

    assign o_link.val = w_s_val;
    assign o_link.gt  = w_gt;
    assign o_s_age    = w_s_age;
    assign o_val      = r_val;
    assign o_age      = r_age;
    assign o_hit      = i_live && (r_age == i_oldest);

    always_comb begin
        priority if (i_left.gt) begin
            n_val = i_left.val;
            n_age = i_left_age + AGE_W'(1);
        end else if (w_gt || !i_valid_n) begin
            n_val = i_x;
            n_age = '0;
        end else begin
            n_val = w_s_val;
            n_age = w_s_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule

/* hw/rtl/swm_out.sv */
// Output stage: saturating median sum and result register
module swm_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pend,
    input  swm_pkg::t_req                   i_req,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_median,
    input  logic                            i_ready,
    output logic                            o_fire,
    output logic                            o_valid,
    output logic [swm_pkg::SAMPLE_BITS-1:0] o_median,
    output logic [swm_pkg::SUM_BITS-1:0]    o_median_sum,
    output logic                            o_is_last
);
    import swm_pkg::*;

    logic [SUM_BITS-1:0] r_sum, n_sum;
    logic [SUM_BITS:0]   w_add;
    logic                r_valid;
    logic [SAMPLE_BITS-1:0] r_median;
    logic [SUM_BITS-1:0] r_msum;
    logic                r_last;

    assign w_add  = {1'b0, r_sum} + (SUM_BITS + 1)'(i_median);
    // saturate on carry out
    assign n_sum  = w_add[SUM_BITS] ? {SUM_BITS{1'b1}} : w_add[SUM_BITS-1:0];
    assign o_fire = i_pend && (!i_req.prod || !r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else begin
            if (o_fire) begin
                if (i_req.last) begin
                    r_sum <= '0;
                end else if (i_req.prod) begin
                    r_sum <= n_sum;
                end
            end
            if (o_fire && i_req.prod) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire && i_req.prod) begin
            r_median <= i_median;
            r_msum   <= n_sum;
            r_last   <= i_req.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_median     = r_median;
    assign o_median_sum = r_msum;
    assign o_is_last    = r_last;

endmodule

/* hw/rtl/sliding_window_median.sv */
// Sliding window median filter: top level with the sorted cell chain
//
// Input requests (i_valid/o_ready) carry one unsigned sample and a last
// flag. Result requests (o_valid/i_ready) carry the lower median of the
// window, the saturating running sum of medians and the last flag.
// The window length comes from i_cfg_data, written with i_cfg_we while idle;
// a write empties the window and keeps the sum.
// A row of WINDOW_MAX cells holds the window in ascending order, each with
// its age. On an accepted sample every cell takes its new value from itself,
// its left or right neighbor or the new sample, dropping the
// oldest entry and inserting the new one.
// Throughput: one sample per cycle while o_ready is high. An accepted sample
// updates the cells and the pending request register; the output stage then
// reads the median cell, adds it to the sum and registers the result.
// No result comes until the window is full. A sample marked last flags its
// result and then empties the window and clears the sum.
// Reset empties the window, clears the sum and sets the length to 3.
// While a result waits in the output register and another is pending,
// o_ready drops until i_ready takes the waiting result.
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [swm_pkg::SAMPLE_BITS-1:0] o_median,
    output logic [swm_pkg::SUM_BITS-1:0]    o_median_sum,
    output logic                            o_is_last,
    input  logic                            i_cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import swm_pkg::*;

    localparam int AGE_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    logic [CFG_BITS-1:0] r_cfg;
    logic [CNT_W-1:0]    r_fill, n_fill, w_eff, w_m1, w_cnt_n;
    logic [CW-1:0]       w_cfg_ext;
    logic                w_full, w_in_fire, w_st_fire, w_prod;
    logic                r_pend;
    t_req                r_req;
    logic [AGE_W-1:0]    w_oldest, w_mid;

    logic [WINDOW_MAX-1:0]  w_hit, w_rle;
    logic [SAMPLE_BITS-1:0] w_val   [WINDOW_MAX];
    logic [AGE_W-1:0]       w_age   [WINDOW_MAX];
    t_link                  w_link  [WINDOW_MAX];
    logic [AGE_W-1:0]       w_s_age [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] w_median;

    // clamp the register to 1..WINDOW_MAX
    assign w_cfg_ext = CW'(r_cfg);
    always_comb begin
        priority if (r_cfg == '0) begin
            w_eff = CNT_W'(1);
        end else if (w_cfg_ext > CW'(WINDOW_MAX)) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(w_cfg_ext);
        end
    end

    assign w_m1     = w_eff - CNT_W'(1);
    assign w_oldest = AGE_W'(w_m1);
    assign w_mid    = AGE_W'(w_m1 >> 1);
    assign w_full   = (r_fill >= w_eff);
    // entries left after the oldest is dropped
    assign w_cnt_n  = w_full ? w_m1 : r_fill;
    assign w_prod   = w_full || ((r_fill + CNT_W'(1)) == w_eff);

    assign o_ready   = !r_pend || w_st_fire;
    assign w_in_fire = i_valid && o_ready;

    always_comb begin
        priority if (i_last) begin
            n_fill = '0;
        end else if (w_full) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg  <= i_cfg_data;
                r_fill <= '0;
            end else if (w_in_fire) begin
                r_fill <= n_fill;
            end
            if (w_in_fire) begin
                r_pend <= 1'b1;
            end else if (w_st_fire) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req.prod <= w_prod;
            r_req.last <= i_last;
        end
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_nxt_val;
        logic [AGE_W-1:0]       w_nxt_age;
        t_link                  w_left;
        logic [AGE_W-1:0]       w_left_age;

        assign w_rle[i] = |w_hit[i:0];

        if (i == WINDOW_MAX - 1) begin : g_end
            assign w_nxt_val = '0;
            assign w_nxt_age = '0;
        end else begin : g_mid
            assign w_nxt_val = w_val[i+1];
            assign w_nxt_age = w_age[i+1];
        end

        if (i == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_age = '0;
        end else begin : g_rest
            assign w_left     = w_link[i-1];
            assign w_left_age = w_s_age[i-1];
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_en       (w_in_fire),
            .i_x        (i_sample),
            .i_rle      (w_rle[i]),
            .i_nxt_val  (w_nxt_val),
            .i_nxt_age  (w_nxt_age),
            .i_valid_n  (CNT_W'(i) < w_cnt_n),
            .i_live     (w_full && (CNT_W'(i) < r_fill)),
            .i_oldest   (w_oldest),
            .i_left     (w_left),
            .i_left_age (w_left_age),
            .o_link     (w_link[i]),
            .o_s_age    (w_s_age[i]),
            .o_val      (w_val[i]),
            .o_age      (w_age[i]),
            .o_hit      (w_hit[i])
        );
    end

    assign w_median = w_val[w_mid];

    swm_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pend       (r_pend),
        .i_req        (r_req),
        .i_median     (w_median),
        .i_ready      (i_ready),
        .o_fire       (w_st_fire),
        .o_valid      (o_valid),
        .o_median     (o_median),
        .o_median_sum (o_median_sum),
        .o_is_last    (o_is_last)
    );

endmodule

/* hw/rtl/swm_checker.sv */
// Port-level checks of the sliding window median filter and their bind
`include "sliding_window_median_macros.svh"

module swm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input logic                            i_last,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [swm_pkg::SAMPLE_BITS-1:0] o_median,
    input logic [swm_pkg::SUM_BITS-1:0]    o_median_sum,
    input logic                            o_is_last,
    input logic                            i_cfg_we
);
    import swm_pkg::*;

    // reset drops any waiting result
    `SWM_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_valid, "result valid after reset")

    // a held result keeps its fields
    `SWM_ASSERT(a_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_median_sum) && $stable(o_median) && $stable(o_is_last)),
        "stalled result changed")

    // the running sum always includes the current median
    `SWM_ASSERT(a_sum_ge, o_valid |-> (o_median_sum >= SUM_BITS'(o_median)),
        "median sum below median")

    // a waiting input request holds its payload
    `SWM_ASSERT(a_in_hold, (i_valid && !o_ready) |=> (i_valid && $stable(i_sample) && $stable(i_last)),
        "waiting input request changed")

    // write the length only while nothing moves
    `SWM_ASSERT(a_cfg_idle, i_cfg_we |-> (!i_valid && !o_valid),
        "length written while busy")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

/* test/swm_median_checker.sv */
// Median filter checker: predicts every result and compares it at the output
`timescale 1ns / 100ps

module swm_median_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_median,
    input  logic [swm_pkg::SUM_BITS-1:0]    i_median_sum,
    input  logic                            i_is_last,
    input  logic                            i_cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]    i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import swm_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] median;
        logic [SUM_BITS-1:0]    sum;
        logic                   is_last;
    } t_median_result;

    t_median_result         expected_medians[$];

    // Window in arrival order and the same samples ranked ascending
    logic [SAMPLE_BITS-1:0] arrival[WINDOW_MAX_DEF];
    logic [SAMPLE_BITS-1:0] ranked[WINDOW_MAX_DEF];
    int unsigned            held;
    int unsigned            oldest;
    logic [SUM_BITS-1:0]    running_sum;
    logic [CFG_BITS-1:0]    size_reg;

    function automatic int unsigned window_len();
        if (size_reg == '0) begin
            return 1;
        end
        if (size_reg > CFG_BITS'(WINDOW_MAX_DEF)) begin
            return WINDOW_MAX_DEF;
        end
        return int'(size_reg);
    endfunction

    task automatic rank_insert(input int unsigned count, input logic [SAMPLE_BITS-1:0] value);
        int unsigned pos;
        pos = count;
        while (pos > 0 && ranked[pos-1] > value) begin
            ranked[pos] = ranked[pos-1];
            pos--;
        end
        ranked[pos] = value;
    endtask

    // Drop one copy of value; later entries close the gap
    task automatic rank_drop(input int unsigned count, input logic [SAMPLE_BITS-1:0] value);
        int unsigned pos;
        pos = 0;
        while (pos < count && ranked[pos] != value) begin
            pos++;
        end
        while (pos + 1 < count) begin
            ranked[pos] = ranked[pos+1];
            pos++;
        end
    endtask

    task automatic advance_window(input logic [SAMPLE_BITS-1:0] value, input logic tail);
        int unsigned      w;
        int unsigned      slot;
        logic [SUM_BITS:0] total;
        t_median_result   res;
        w = window_len();
        if (held >= w) begin
            slot = oldest % w;
            rank_drop(w, arrival[slot]);
            rank_insert(w - 1, value);
            arrival[slot] = value;
            oldest = (slot + 1 == w) ? 0 : slot + 1;
            held = w;
        end else begin
            arrival[held] = value;
            rank_insert(held, value);
            held++;
        end
        if (held == w) begin
            res.median  = ranked[(w + 1) / 2 - 1];
            total       = {1'b0, running_sum} + res.median;
            running_sum = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
            res.sum     = running_sum;
            res.is_last = tail;
            expected_medians.insert(expected_medians.size(), res);
        end
        if (tail) begin
            held        = 0;
            oldest      = 0;
            running_sum = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_median_result want;
        if (!i_rst_n) begin
            held        = 0;
            oldest      = 0;
            running_sum = '0;
            size_reg    = CFG_RESET;
            expected_medians.delete();
        end else begin
            // Compare before the new request is predicted: results lag their sample
            if (i_out_valid && i_out_ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch("result with no request waiting", 64'(i_median), 64'(0));
                end else begin
                    want = expected_medians.pop_front();
                    if (i_median !== want.median) begin
                        report_mismatch("median", 64'(i_median), 64'(want.median));
                    end
                    if (i_median_sum !== want.sum) begin
                        report_mismatch("median_sum", 64'(i_median_sum), 64'(want.sum));
                    end
                    if (i_is_last !== want.is_last) begin
                        report_mismatch("is_last", 64'(i_is_last), 64'(want.is_last));
                    end
                end
            end
            if (i_cfg_we) begin
                size_reg = i_cfg_data;
                held     = 0;
                oldest   = 0;
            end
            if (i_in_valid && i_in_ready) begin
                advance_window(i_sample, i_last);
            end
        end
        o_pending = expected_medians.size();
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the sliding window median filter: stimulus phases and verdict
`timescale 1ns / 100ps

module tb_top;
    import swm_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   i_last;
    logic                   o_valid;
    logic                   i_ready;
    logic [SAMPLE_BITS-1:0] o_median;
    logic [SUM_BITS-1:0]    o_median_sum;
    logic                   o_is_last;
    logic                   i_cfg_we;
    logic [CFG_BITS-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;

    sliding_window_median dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_median    (o_median),
        .o_median_sum(o_median_sum),
        .o_is_last   (o_is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    swm_median_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_median    (o_median),
        .i_median_sum(o_median_sum),
        .i_is_last   (o_is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Mostly random, some from a tiny range to force equal samples, some extremes
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            return SAMPLE_BITS'($urandom);
        end
        if (k < 9) begin
            return SAMPLE_BITS'($urandom_range(0, 7));
        end
        return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic tail);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        i_last   <= tail;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold off until every expected result is out and the pipeline has settled
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] size_cfg, input int unsigned budget);
        int unsigned w;
        int unsigned len;
        int unsigned n;
        int unsigned k;
        bit          broken;
        bit          tail_last;
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size_cfg;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        w = (size_cfg == '0) ? 1 :
            ((size_cfg > CFG_BITS'(WINDOW_MAX_DEF)) ? WINDOW_MAX_DEF : int'(size_cfg));
        n = 0;
        while (n < budget) begin
            // Mostly full windows ending in last; some sequences cut short
            broken    = ($urandom_range(0, 4) == 0);
            len       = broken ? $urandom_range(1, w) : w + $urandom_range(0, 2 * w + 4);
            tail_last = broken || ($urandom_range(0, 6) != 0);
            for (k = 1; k <= len; k++) begin
                send_sample(pick_sample(), tail_last && (k == len));
            end
            n += len;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_last      = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        tx_idle_pct = 25;
        rx_idle_pct = 52;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Window of three from reset: extremes, equal samples, early last
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);

        run_phase(CFG_BITS'(1), 85);
        run_phase(CFG_BITS'(2), 85);
        run_phase(CFG_BITS'(0), 85);
        run_phase(CFG_BITS'(5), 85);
        run_phase(CFG_BITS'(127), 85);
        run_phase(CFG_BITS'($urandom_range(1, 16)), 85);

        tx_idle_pct = 52;
        rx_idle_pct = 25;
        run_phase(CFG_BITS'(4), 85);
        run_phase(CFG_BITS'($urandom_range(0, 20)), 85);
        run_phase(CFG_BITS'(65), 85);
        run_phase(CFG_BITS'(3), 85);
        run_phase(CFG_BITS'(7), 85);
        run_phase(CFG_BITS'(2), 85);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(CFG_BITS'($urandom_range(1, 16)), 85);
        run_phase(CFG_BITS'(0), 85);
        run_phase(CFG_BITS'(8), 85);
        run_phase(CFG_BITS'(64), 85);
        run_phase(CFG_BITS'(3), 85);
        run_phase(CFG_BITS'(1), 85);

        wait_drained();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
